>>> rtl/bup_pkg.sv
// ----------------------------------------------------------------------------
// bup_pkg
// Shared types, constants and the character decode for the UUID text parser.
// ----------------------------------------------------------------------------
package bup_pkg;

  localparam logic [5:0] TEXT_LEN_FULL = 6'd36;
  localparam logic [7:0] CHAR_HYPHEN   = 8'h2d;

  localparam logic [5:0] HYPHEN_POS_A = 6'd8;
  localparam logic [5:0] HYPHEN_POS_B = 6'd13;
  localparam logic [5:0] HYPHEN_POS_C = 6'd18;
  localparam logic [5:0] HYPHEN_POS_D = 6'd23;

  localparam logic [63:0] BASE_HIGH = 64'h0000_0000_0000_1000;
  localparam logic [63:0] BASE_LOW  = 64'h8000_0080_5f9b_34fb;

  localparam logic [1:0] SIZE_16  = 2'd0;
  localparam logic [1:0] SIZE_32  = 2'd1;
  localparam logic [1:0] SIZE_128 = 2'd2;
  localparam logic [1:0] SIZE_BAD = 2'd3;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [3:0] nibble;
    logic       shift;
    logic       err;
    logic       last;
    logic [1:0] len_code;
  } cls_t;

  typedef struct packed {
    logic       hex;
    logic [3:0] value;
  } nib_t;

  function automatic nib_t nibble_of(input logic [7:0] c);
    nib_t r;
    r.hex   = 1'b0;
    r.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.hex   = 1'b1;
      r.value = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r.hex   = 1'b1;
      r.value = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r.hex   = 1'b1;
      r.value = 4'(c - 8'h37);
    end
    return r;
  endfunction

endpackage

>>> rtl/bup_front.sv
// ----------------------------------------------------------------------------
// bup_front
// Tracks the character position and classifies each character of the text.
// ----------------------------------------------------------------------------
module bup_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          take,
  input  logic [7:0]    char_code,
  input  logic          last_char,
  output bup_pkg::cls_t cls
);

  logic [5:0]     pos_r;
  logic [5:0]     pos_nxt;
  logic [5:0]     pos_inc;
  logic           at_end;
  logic           hyphen_slot;
  bup_pkg::nib_t  nib;

  always_comb begin
    nib         = bup_pkg::nibble_of(char_code);
    at_end      = pos_r >= bup_pkg::TEXT_LEN_FULL;
    pos_inc     = pos_r + 6'd1;
    hyphen_slot = pos_r == bup_pkg::HYPHEN_POS_A || pos_r == bup_pkg::HYPHEN_POS_B ||
                  pos_r == bup_pkg::HYPHEN_POS_C || pos_r == bup_pkg::HYPHEN_POS_D;

    cls.nibble = nib.value;
    cls.last   = last_char;
    cls.shift  = !at_end && !hyphen_slot && nib.hex;
    cls.err    = at_end || (hyphen_slot ? (char_code != bup_pkg::CHAR_HYPHEN) : !nib.hex);

    priority if (at_end) begin
      cls.len_code = bup_pkg::SIZE_BAD;
    end else if (pos_inc == 6'd4) begin
      cls.len_code = bup_pkg::SIZE_16;
    end else if (pos_inc == 6'd8) begin
      cls.len_code = bup_pkg::SIZE_32;
    end else if (pos_inc == bup_pkg::TEXT_LEN_FULL) begin
      cls.len_code = bup_pkg::SIZE_128;
    end else begin
      cls.len_code = bup_pkg::SIZE_BAD;
    end

    pos_nxt = pos_r;
    if (take) begin
      pos_nxt = last_char ? 6'd0 : (at_end ? pos_r : pos_inc);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= 6'd0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

endmodule

>>> rtl/bup_queue.sv
// ----------------------------------------------------------------------------
// bup_queue
// Two-entry queue of classified characters between front and back.
// ----------------------------------------------------------------------------
module bup_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  bup_pkg::cls_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          avail,
  output bup_pkg::cls_t head
);

  bup_pkg::cls_t mem_r [bup_pkg::QUEUE_DEPTH];
  logic          wr_ptr_r;
  logic          rd_ptr_r;
  logic [1:0]    count_r;
  logic [1:0]    count_nxt;
  logic          do_push;
  logic          do_pop;

  always_comb begin
    full    = count_r == 2'(bup_pkg::QUEUE_DEPTH);
    avail   = count_r != 2'd0;
    head    = mem_r[rd_ptr_r];
    do_push = push && !full;
    do_pop  = pop && avail;
    count_nxt = count_r;
    unique case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 2'd1;
      2'b01:   count_nxt = count_r - 2'd1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

endmodule

>>> rtl/bup_back.sv
// ----------------------------------------------------------------------------
// bup_back
// Shifts hex digits into the accumulator and builds the expanded UUID result.
// ----------------------------------------------------------------------------
module bup_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          avail,
  input  bup_pkg::cls_t head,
  output logic          pop,
  input  logic          res_pop,
  output logic          res_valid,
  output logic          res_ok,
  output logic [1:0]    res_size,
  output logic [63:0]   res_high,
  output logic [63:0]   res_low
);

  logic [127:0] acc_r;
  logic [127:0] acc_nxt;
  logic         bad_r;
  logic         bad_nxt;
  logic         out_v_r;
  logic         ok_r;
  logic [1:0]   size_r;
  logic [63:0]  high_r;
  logic [63:0]  low_r;
  logic         ok_nxt;
  logic [1:0]   size_nxt;
  logic [63:0]  high_nxt;
  logic [63:0]  low_nxt;
  logic         out_busy;

  always_comb begin
    out_busy = out_v_r && !res_pop;
    pop      = avail && !(head.last && out_busy);
    acc_nxt  = head.shift ? {acc_r[123:0], head.nibble} : acc_r;
    bad_nxt  = bad_r || head.err;
    ok_nxt   = !bad_nxt && head.len_code != bup_pkg::SIZE_BAD;
    size_nxt = 2'd0;
    high_nxt = 64'd0;
    low_nxt  = 64'd0;
    if (ok_nxt) begin
      unique case (head.len_code)
        bup_pkg::SIZE_16: begin
          size_nxt = bup_pkg::SIZE_16;
          high_nxt = {16'd0, acc_nxt[15:0], 32'd0} | bup_pkg::BASE_HIGH;
          low_nxt  = bup_pkg::BASE_LOW;
        end
        bup_pkg::SIZE_32: begin
          size_nxt = bup_pkg::SIZE_32;
          high_nxt = {acc_nxt[31:0], 32'd0} | bup_pkg::BASE_HIGH;
          low_nxt  = bup_pkg::BASE_LOW;
        end
        default: begin
          size_nxt = bup_pkg::SIZE_128;
          high_nxt = acc_nxt[127:64];
          low_nxt  = acc_nxt[63:0];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.last) begin
      ok_r   <= ok_nxt;
      size_r <= size_nxt;
      high_r <= high_nxt;
      low_r  <= low_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= 128'd0;
      bad_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (pop) begin
        if (head.last) begin
          acc_r <= 128'd0;
          bad_r <= 1'b0;
        end else begin
          acc_r <= acc_nxt;
          bad_r <= bad_nxt;
        end
      end
      if (pop && head.last) begin
        out_v_r <= 1'b1;
      end else if (res_pop) begin
        out_v_r <= 1'b0;
      end
    end
  end

  assign res_valid = out_v_r;
  assign res_ok    = ok_r;
  assign res_size  = size_r;
  assign res_high  = high_r;
  assign res_low   = low_r;

endmodule

>>> rtl/ble_uuid_text_parser.sv
// ----------------------------------------------------------------------------
// ble_uuid_text_parser
// Throughput: one character per cycle, set by the front classifier and the
// back-end accumulator shift, while the queue has room. A last character
// waits in the queue while an unread result is held in the result register.
// Reset: synchronous; clears position, accumulator, error flag and the queue.
// Streaming parser of UUID text into the expanded 128-bit Bluetooth UUID.
// ----------------------------------------------------------------------------
module ble_uuid_text_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_char_code,
  input  logic        in_last_char,
  output logic        out_empty,
  input  logic        out_pop,
  output logic        out_uuid_ok,
  output logic [1:0]  out_size_code,
  output logic [63:0] out_uuid_high,
  output logic [63:0] out_uuid_low
);

  bup_pkg::cls_t cls;
  bup_pkg::cls_t head;
  logic          q_full;
  logic          q_avail;
  logic          q_pop;
  logic          res_valid;
  logic          take;

  assign take    = in_push && !q_full;
  assign in_full = q_full;

  bup_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .char_code (in_char_code),
    .last_char (in_last_char),
    .cls       (cls)
  );

  bup_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (take),
    .push_data (cls),
    .full      (q_full),
    .pop       (q_pop),
    .avail     (q_avail),
    .head      (head)
  );

  bup_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .avail     (q_avail),
    .head      (head),
    .pop       (q_pop),
    .res_pop   (out_pop),
    .res_valid (res_valid),
    .res_ok    (out_uuid_ok),
    .res_size  (out_size_code),
    .res_high  (out_uuid_high),
    .res_low   (out_uuid_low)
  );

  assign out_empty = !res_valid;

endmodule
